// File: hdl/biquad_clip_lowpass_chain_macros.svh
// Assertion macros for the biquad chain.
`ifndef BIQUAD_CLIP_LOWPASS_CHAIN_MACROS_SVH
`define BIQUAD_CLIP_LOWPASS_CHAIN_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define BQC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define BQC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: hdl/bqc_pkg.sv
// Shared types, constants and helpers of the biquad chain.
`default_nettype none
package bqc_pkg;
  localparam int MAX_CHANNELS = 16;
  localparam int CH_W = $clog2(MAX_CHANNELS);
  localparam int MEM_DEPTH = 2 * MAX_CHANNELS;
  localparam int ADDR_W = $clog2(MEM_DEPTH);
  localparam int COEF_W = 20;
  localparam int SIG_W = 32;
  localparam int PROD_W = SIG_W + COEF_W;
  localparam int ACC_W = PROD_W + 2;

  localparam logic [2:0] REG_EQ1_NUM = 3'd0;
  localparam logic [2:0] REG_EQ1_DEN = 3'd1;
  localparam logic [2:0] REG_EQ2_NUM = 3'd2;
  localparam logic [2:0] REG_EQ2_DEN = 3'd3;
  localparam logic [2:0] REG_LP_NUM  = 3'd4;
  localparam logic [2:0] REG_LP_DEN  = 3'd5;
  localparam logic [2:0] REG_CLIP    = 3'd6;
  localparam logic [2:0] REG_CHCNT   = 3'd7;

  // multiply ops of the shared serial multiplier
  typedef enum logic [2:0] {
    OP_B0, OP_B1, OP_A1, OP_B2, OP_A2
  } mop_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_RD, ST_RDW, ST_MUL, ST_MULW, ST_ACC,
    ST_WR, ST_CLIP, ST_OUT
  } state_t;

  typedef struct packed {
    logic                     start;
    logic signed [SIG_W-1:0]  sig;
    logic signed [COEF_W-1:0] coef;
  } mul_req_t;

  function automatic logic signed [SIG_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(64'sd2147483647);
    lo = -hi - ACC_W'(1);
    if (v > hi) return hi[SIG_W-1:0];
    else if (v < lo) return lo[SIG_W-1:0];
    else return v[SIG_W-1:0];
  endfunction

  // round half up by 17 bits
  function automatic logic signed [ACC_W-1:0] rnd17(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v + ACC_W'(65536);
    return t >>> 17;
  endfunction
endpackage
`default_nettype wire

// File: hdl/bqc_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module bqc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem_r[addr] <= wdata;
    rdata <= mem_r[addr];
  end
endmodule
`default_nettype wire

// File: hdl/bqc_mul.sv
// Bit-serial signed multiplier: one coefficient bit per cycle.
`default_nettype none
module bqc_mul (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bqc_pkg::mul_req_t req,
  output logic                   done,
  output logic signed [bqc_pkg::PROD_W-1:0] prod
);
  localparam int CNT_W = $clog2(bqc_pkg::COEF_W + 1);
  logic signed [bqc_pkg::PROD_W-1:0] acc_r, acc_nxt;
  logic [bqc_pkg::COEF_W-1:0] coef_r, coef_nxt;
  logic signed [bqc_pkg::PROD_W-1:0] mcand_r, mcand_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;

  always_comb begin
    acc_nxt = acc_r;
    coef_nxt = coef_r;
    mcand_nxt = mcand_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      acc_nxt = '0;
      coef_nxt = req.coef;
      mcand_nxt = bqc_pkg::PROD_W'(req.sig);
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // top coefficient bit has negative weight
      if (coef_r[0]) begin
        if (cnt_r == CNT_W'(bqc_pkg::COEF_W - 1)) acc_nxt = acc_r - mcand_r;
        else acc_nxt = acc_r + mcand_r;
      end
      coef_nxt = coef_r >> 1;
      mcand_nxt = mcand_r <<< 1;
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(bqc_pkg::COEF_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    coef_r <= coef_nxt;
    mcand_r <= mcand_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule
`default_nettype wire

// File: hdl/biquad_clip_lowpass_chain.sv
// Top level: control sequencer, configuration and filter state of the chain.
`default_nettype none
`include "biquad_clip_lowpass_chain_macros.svh"
// Three biquads (two equalizers, hard clip, lowpass) on interleaved channels,
// computed with one bit-serial 32x20 multiplier. Each stage reads its two
// state words, issues and accumulates 5 products and writes both state words
// back; the clip step follows the second biquad and the output step the third.
// One item is in work at a time: the next input beat is taken only once the
// sequencer has left its output step. A result waiting in the output register
// does not block the next input beat; the sequencer only holds at its output
// step until that register is free. After reset a clearing pass over all
// 32 entries zeroes the filter state RAMs before the first input beat is
// accepted.
module biquad_clip_lowpass_chain (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic signed [15:0] in_sample_in,
  input  wire logic        in_block_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [15:0] out_sample_out,
  output logic [3:0]       out_channel_index,
  output logic             out_block_end,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [59:0] cfg_data
);
  localparam int AW = bqc_pkg::ADDR_W;
  localparam int CW = bqc_pkg::CH_W;
  localparam int SW = bqc_pkg::SIG_W;
  localparam int AC = bqc_pkg::ACC_W;

  logic [59:0] num_r [3];
  logic [39:0] den_r [3];
  logic [14:0] clip_r;
  logic [4:0]  chcnt_r;

  bqc_pkg::state_t st_r, st_nxt;
  logic [1:0] stg_r, stg_nxt;
  bqc_pkg::mop_t op_r, op_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [CW-1:0] ctr_r, ctr_nxt, ch_r, ch_nxt;
  logic last_r, last_nxt;
  logic signed [SW-1:0] x_r, x_nxt, y_r, y_nxt, s1_r, s1_nxt, s2_r, s2_nxt;
  logic signed [AC-1:0] acc_r, acc_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [15:0] out_smp_r, out_smp_nxt;
  logic [CW-1:0] out_ch_r, out_ch_nxt;
  logic out_last_r, out_last_nxt;
  logic rd_sel_r, rd_sel_nxt;

  bqc_pkg::mul_req_t mreq;
  logic mdone;
  logic signed [bqc_pkg::PROD_W-1:0] mprod;

  logic [2:0] ram_we;
  logic [AW-1:0] ram_addr;
  logic [SW-1:0] ram_wdata;
  logic [SW-1:0] ram_rdata [3];

  bqc_mul u_mul (.clk, .rst_n, .req(mreq), .done(mdone), .prod(mprod));

  for (genvar g = 0; g < 3; g++) begin : g_mem
    bqc_ram #(.WIDTH(SW), .DEPTH(bqc_pkg::MEM_DEPTH)) u_ram (
      .clk, .we(ram_we[g]), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata[g]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= 60'h200000000000000;
        den_r[i] <= '0;
      end
      clip_r <= 15'd31457;
      chcnt_r <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        bqc_pkg::REG_EQ1_NUM: num_r[0] <= cfg_data;
        bqc_pkg::REG_EQ1_DEN: den_r[0] <= cfg_data[39:0];
        bqc_pkg::REG_EQ2_NUM: num_r[1] <= cfg_data;
        bqc_pkg::REG_EQ2_DEN: den_r[1] <= cfg_data[39:0];
        bqc_pkg::REG_LP_NUM:  num_r[2] <= cfg_data;
        bqc_pkg::REG_LP_DEN:  den_r[2] <= cfg_data[39:0];
        bqc_pkg::REG_CLIP:    clip_r <= cfg_data[14:0];
        bqc_pkg::REG_CHCNT:   chcnt_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  logic [5:0] cnt_eff;
  logic [5:0] ch_plus;
  logic signed [bqc_pkg::COEF_W-1:0] coef_sel;
  logic signed [AC-1:0] prod_x;
  logic signed [AC-1:0] clipv;
  logic signed [AC-1:0] r9;

  always_comb begin
    if (chcnt_r == 5'd0) cnt_eff = 6'd1;
    else if ({1'b0, chcnt_r} > 6'(bqc_pkg::MAX_CHANNELS)) cnt_eff = 6'(bqc_pkg::MAX_CHANNELS);
    else cnt_eff = {1'b0, chcnt_r};
    ch_plus = 6'(ch_r) + 6'd1;
    case (op_r)
      bqc_pkg::OP_B0: coef_sel = num_r[stg_r][59:40];
      bqc_pkg::OP_B1: coef_sel = num_r[stg_r][39:20];
      bqc_pkg::OP_B2: coef_sel = num_r[stg_r][19:0];
      bqc_pkg::OP_A1: coef_sel = den_r[stg_r][39:20];
      bqc_pkg::OP_A2: coef_sel = den_r[stg_r][19:0];
      default:        coef_sel = '0;
    endcase
    prod_x = AC'(mprod);
    clipv = AC'($signed({1'b0, clip_r, 9'd0}));
    r9 = (AC'(y_r) + AC'(256)) >>> 9;
  end

  always_comb begin
    st_nxt = st_r;
    stg_nxt = stg_r;
    op_nxt = op_r;
    clr_nxt = clr_r;
    ctr_nxt = ctr_r;
    ch_nxt = ch_r;
    last_nxt = last_r;
    x_nxt = x_r;
    y_nxt = y_r;
    s1_nxt = s1_r;
    s2_nxt = s2_r;
    acc_nxt = acc_r;
    out_valid_nxt = out_valid_r;
    out_smp_nxt = out_smp_r;
    out_ch_nxt = out_ch_r;
    out_last_nxt = out_last_r;
    rd_sel_nxt = rd_sel_r;
    in_ready = 1'b0;
    mreq = '0;
    ram_we = '0;
    ram_addr = {ch_r, rd_sel_r};
    ram_wdata = s1_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (st_r)
      bqc_pkg::ST_CLEAR: begin
        ram_we = 3'b111;
        ram_addr = clr_r;
        ram_wdata = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(bqc_pkg::MEM_DEPTH - 1)) st_nxt = bqc_pkg::ST_IDLE;
      end
      bqc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ch_nxt = ({1'b0, ctr_r} < cnt_eff[CW:0]) ? ctr_r : '0;
          last_nxt = in_block_last;
          x_nxt = SW'(in_sample_in) <<< 9;
          stg_nxt = 2'd0;
          rd_sel_nxt = 1'b0;
          st_nxt = bqc_pkg::ST_RD;
        end
      end
      bqc_pkg::ST_RD: begin
        // address {ch, rd_sel} on the RAM this cycle
        st_nxt = bqc_pkg::ST_RDW;
      end
      bqc_pkg::ST_RDW: begin
        if (!rd_sel_r) begin
          s1_nxt = ram_rdata[stg_r];
          rd_sel_nxt = 1'b1;
          st_nxt = bqc_pkg::ST_RD;
        end else begin
          s2_nxt = ram_rdata[stg_r];
          op_nxt = bqc_pkg::OP_B0;
          st_nxt = bqc_pkg::ST_MUL;
        end
      end
      bqc_pkg::ST_MUL: begin
        mreq.start = 1'b1;
        mreq.coef = coef_sel;
        mreq.sig = (op_r == bqc_pkg::OP_A1 || op_r == bqc_pkg::OP_A2) ? y_r : x_r;
        st_nxt = bqc_pkg::ST_MULW;
      end
      bqc_pkg::ST_MULW: begin
        if (mdone) st_nxt = bqc_pkg::ST_ACC;
      end
      bqc_pkg::ST_ACC: begin
        st_nxt = bqc_pkg::ST_MUL;
        case (op_r)
          bqc_pkg::OP_B0: begin
            y_nxt = bqc_pkg::sat32(bqc_pkg::rnd17(prod_x) + AC'(s1_r));
            op_nxt = bqc_pkg::OP_B1;
          end
          bqc_pkg::OP_B1: begin
            acc_nxt = prod_x;
            op_nxt = bqc_pkg::OP_A1;
          end
          bqc_pkg::OP_A1: begin
            s1_nxt = bqc_pkg::sat32(bqc_pkg::rnd17(acc_r - prod_x) + AC'(s2_r));
            op_nxt = bqc_pkg::OP_B2;
          end
          bqc_pkg::OP_B2: begin
            acc_nxt = prod_x;
            op_nxt = bqc_pkg::OP_A2;
          end
          default: begin
            s2_nxt = bqc_pkg::sat32(bqc_pkg::rnd17(acc_r - prod_x));
            rd_sel_nxt = 1'b0;
            st_nxt = bqc_pkg::ST_WR;
          end
        endcase
      end
      bqc_pkg::ST_WR: begin
        ram_we[stg_r] = 1'b1;
        ram_wdata = rd_sel_r ? s2_r : s1_r;
        rd_sel_nxt = !rd_sel_r;
        if (rd_sel_r) begin
          rd_sel_nxt = 1'b0;
          x_nxt = y_r;
          if (stg_r == 2'd1) st_nxt = bqc_pkg::ST_CLIP;
          else if (stg_r == 2'd2) st_nxt = bqc_pkg::ST_OUT;
          else begin
            stg_nxt = stg_r + 2'd1;
            st_nxt = bqc_pkg::ST_RD;
          end
        end
      end
      bqc_pkg::ST_CLIP: begin
        if (AC'(y_r) > clipv) x_nxt = clipv[SW-1:0];
        else if (AC'(y_r) < -clipv) x_nxt = SW'(-clipv);
        stg_nxt = 2'd2;
        st_nxt = bqc_pkg::ST_RD;
      end
      bqc_pkg::ST_OUT: begin
        // hold here while the previous result beat still waits
        if (!out_valid_r || out_ready) begin
          if (r9 > AC'(32767)) out_smp_nxt = 16'sd32767;
          else if (r9 < -AC'(32768)) out_smp_nxt = -16'sd32768;
          else out_smp_nxt = r9[15:0];
          out_ch_nxt = ch_r;
          out_last_nxt = last_r;
          out_valid_nxt = 1'b1;
          ctr_nxt = (last_r || ch_plus >= cnt_eff) ? '0 : ch_plus[CW-1:0];
          st_nxt = bqc_pkg::ST_IDLE;
        end
      end
      default: st_nxt = bqc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= bqc_pkg::ST_CLEAR;
      clr_r <= '0;
      ctr_r <= '0;
      out_valid_r <= 1'b0;
      stg_r <= '0;
      op_r <= bqc_pkg::OP_B0;
      rd_sel_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      clr_r <= clr_nxt;
      ctr_r <= ctr_nxt;
      out_valid_r <= out_valid_nxt;
      stg_r <= stg_nxt;
      op_r <= op_nxt;
      rd_sel_r <= rd_sel_nxt;
    end
    ch_r <= ch_nxt;
    last_r <= last_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
    acc_r <= acc_nxt;
    out_smp_r <= out_smp_nxt;
    out_ch_r <= out_ch_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_sample_out = out_smp_r;
  assign out_channel_index = out_ch_r;
  assign out_block_end = out_last_r;

  `BQC_ASSERT_IMP(a_ready_only_idle, in_ready, st_r == bqc_pkg::ST_IDLE)
  `BQC_ASSERT_IMP(a_stage_range, 1'b1, stg_r != 2'd3)
  `BQC_ASSERT_NXT(a_out_after_final, st_r == bqc_pkg::ST_OUT, out_valid_r)
  `BQC_ASSERT_NXT(a_out_hold, out_valid_r && !out_ready, out_valid_r)
  `BQC_ASSERT_IMP(a_mul_idle_on_start, st_r == bqc_pkg::ST_MUL, !mdone)
endmodule
`default_nettype wire
